[design/cpualu_pkg.sv]
// Package for the 8-bit CPU ALU with Z/N/H/C flags.
// Operation codes, flag bit positions and the item types.
// No dependencies.
package cpualu_pkg;

	localparam int OP_W   = 5;
	localparam int BYTE_W = 8;
	localparam int WIDE_W = 16;
	localparam int FLAG_W = 4;

	localparam logic [OP_W-1:0] OP_ADD   = 5'd0;
	localparam logic [OP_W-1:0] OP_ADC   = 5'd1;
	localparam logic [OP_W-1:0] OP_SUB   = 5'd2;
	localparam logic [OP_W-1:0] OP_SBC   = 5'd3;
	localparam logic [OP_W-1:0] OP_AND   = 5'd4;
	localparam logic [OP_W-1:0] OP_INC   = 5'd5;
	localparam logic [OP_W-1:0] OP_DEC   = 5'd6;
	localparam logic [OP_W-1:0] OP_RLCA  = 5'd7;
	localparam logic [OP_W-1:0] OP_RRCA  = 5'd8;
	localparam logic [OP_W-1:0] OP_RLA   = 5'd9;
	localparam logic [OP_W-1:0] OP_RRA   = 5'd10;
	localparam logic [OP_W-1:0] OP_DAA   = 5'd11;
	localparam logic [OP_W-1:0] OP_CPL   = 5'd12;
	localparam logic [OP_W-1:0] OP_SCF   = 5'd13;
	localparam logic [OP_W-1:0] OP_CCF   = 5'd14;
	localparam logic [OP_W-1:0] OP_ADD16 = 5'd15;
	localparam logic [OP_W-1:0] OP_INC16 = 5'd16;
	localparam logic [OP_W-1:0] OP_DEC16 = 5'd17;

	// flag bit positions
	localparam int FZ = 3;
	localparam int FN = 2;
	localparam int FH = 1;
	localparam int FC = 0;

	localparam logic [BYTE_W-1:0] DAA_HI_ADJ = 8'h60;
	localparam logic [BYTE_W-1:0] DAA_LO_ADJ = 8'h06;
	localparam logic [BYTE_W-1:0] DAA_LIMIT  = 8'h99;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] operand_a;
		logic [BYTE_W-1:0] operand_b;
		logic [WIDE_W-1:0] wide_a;
		logic [WIDE_W-1:0] wide_b;
		logic [FLAG_W-1:0] flags_in;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_result;
		logic [WIDE_W-1:0] wide_result;
		logic [FLAG_W-1:0] flags_out;
	} out_item_t;

endpackage

[design/cpualu_in_if.sv]
// Input channel of the CPU ALU: valid/ready plus one operation item.
// Depends on cpualu_pkg.
interface cpualu_in_if;
	logic                          valid;
	logic                          ready;
	logic [cpualu_pkg::OP_W-1:0]   op;
	logic [cpualu_pkg::BYTE_W-1:0] operand_a;
	logic [cpualu_pkg::BYTE_W-1:0] operand_b;
	logic [cpualu_pkg::WIDE_W-1:0] wide_a;
	logic [cpualu_pkg::WIDE_W-1:0] wide_b;
	logic [cpualu_pkg::FLAG_W-1:0] flags_in;

	modport source (output valid, op, operand_a, operand_b, wide_a, wide_b, flags_in,
		input ready);
	modport sink (input valid, op, operand_a, operand_b, wide_a, wide_b, flags_in,
		output ready);
endinterface

[design/cpualu_out_if.sv]
// Output channel of the CPU ALU: valid/ready plus one result item.
// Depends on cpualu_pkg.
interface cpualu_out_if;
	logic                          valid;
	logic                          ready;
	logic [cpualu_pkg::BYTE_W-1:0] byte_result;
	logic [cpualu_pkg::WIDE_W-1:0] wide_result;
	logic [cpualu_pkg::FLAG_W-1:0] flags_out;

	modport source (output valid, byte_result, wide_result, flags_out, input ready);
	modport sink (input valid, byte_result, wide_result, flags_out, output ready);
endinterface

[design/cpu_alu_with_flags_top.sv]
// Top level of the 8-bit CPU ALU with Z/N/H/C flags.
// Depends on cpualu_pkg, cpualu_in_if, cpualu_out_if and cpualu_core.
//
// Usage:
//   item_in carries one operation (op, two bytes, two 16-bit words and
//   the current flags); item_out returns the byte result, the 16-bit
//   result and the new flags. Both use valid/ready; an item moves on a
//   rising edge with valid and ready high. Every item gives one result,
//   in order.
//   The item is captured in the input register, the ALU logic works on it
//   there and the result register presents the result.
//   Throughput is one item per cycle while item_out.ready stays high.
//   When the receiver stalls, the result register holds and the input
//   register keeps accepting until it is full as well; item_in.ready then
//   drops until item_out.ready returns.
//   arst_n clears both valid bits; the data registers are not reset.
module cpu_alu_with_flags_top (
	input  logic         clk,
	input  logic         arst_n,
	cpualu_in_if.sink    item_in,
	cpualu_out_if.source item_out
);

	logic                  v_s1;
	logic                  v_s2;
	cpualu_pkg::in_item_t  item_s1;
	cpualu_pkg::out_item_t res_s2;
	cpualu_pkg::out_item_t res_comb;
	logic                  adv;
	logic                  in_rdy;

	assign adv    = !v_s2 || item_out.ready;
	assign in_rdy = !v_s1 || adv;

	assign item_in.ready = in_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_rdy)
				v_s1 <= item_in.valid;
			if (adv)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.valid && in_rdy) begin
			item_s1.op        <= item_in.op;
			item_s1.operand_a <= item_in.operand_a;
			item_s1.operand_b <= item_in.operand_b;
			item_s1.wide_a    <= item_in.wide_a;
			item_s1.wide_b    <= item_in.wide_b;
			item_s1.flags_in  <= item_in.flags_in;
		end
		if (v_s1 && adv)
			res_s2 <= res_comb;
	end

	cpualu_core u_core (
		.item (item_s1),
		.res  (res_comb)
	);

	assign item_out.valid       = v_s2;
	assign item_out.byte_result = res_s2.byte_result;
	assign item_out.wide_result = res_s2.wide_result;
	assign item_out.flags_out   = res_s2.flags_out;

	// full pipeline with a stalled receiver must refuse new items
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && !item_out.ready) |-> !item_in.ready)
		else $error("input accepted while pipeline full and stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		(item_in.valid && item_in.ready) |=> v_s1)
		else $error("accepted item missing from input register");

	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv) |=> item_out.valid)
		else $error("advancing item missing from result register");

	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !item_out.ready) |=> (v_s2 && $stable(res_s2)))
		else $error("stalled result changed");

endmodule

[design/cpualu_core.sv]
// Combinational datapath of the CPU ALU: one item in, one result out.
// Depends on cpualu_pkg.
module cpualu_core (
	input  cpualu_pkg::in_item_t  item,
	output cpualu_pkg::out_item_t res
);

	logic [7:0]  a, b, r;
	logic [15:0] w;
	logic [3:0]  f, nf;
	logic        cin, cuse;
	logic [8:0]  sum9, dif9;
	logic [4:0]  hsum, hdif;
	logic [16:0] sum17;
	logic [12:0] sum13;
	logic        daa_c;
	logic [7:0]  adj;

	assign a   = item.operand_a;
	assign b   = item.operand_b;
	assign f   = item.flags_in;
	assign cin = f[cpualu_pkg::FC];

	// carry only for adc/sbc
	assign cuse = (item.op == cpualu_pkg::OP_ADC || item.op == cpualu_pkg::OP_SBC) ? cin : 1'b0;

	assign sum9  = {1'b0, a} + {1'b0, b} + {8'd0, cuse};
	assign hsum  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cuse};
	assign dif9  = {1'b0, a} - {1'b0, b} - {8'd0, cuse};
	assign hdif  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cuse};
	assign sum17 = {1'b0, item.wide_a} + {1'b0, item.wide_b};
	assign sum13 = {1'b0, item.wide_a[11:0]} + {1'b0, item.wide_b[11:0]};

	always_comb begin
		daa_c = cin;
		adj   = '0;
		if (!f[cpualu_pkg::FN]) begin
			if (cin || a > cpualu_pkg::DAA_LIMIT) begin
				adj   = adj | cpualu_pkg::DAA_HI_ADJ;
				daa_c = 1'b1;
			end
			if (f[cpualu_pkg::FH] || a[3:0] > 4'h9)
				adj = adj | cpualu_pkg::DAA_LO_ADJ;
		end else begin
			if (cin)
				adj = adj | cpualu_pkg::DAA_HI_ADJ;
			if (f[cpualu_pkg::FH])
				adj = adj | cpualu_pkg::DAA_LO_ADJ;
		end
	end

	always_comb begin
		r  = a;
		w  = item.wide_a;
		nf = f;
		unique case (item.op) inside
			cpualu_pkg::OP_ADD, cpualu_pkg::OP_ADC: begin
				r  = sum9[7:0];
				nf = {r == 8'd0, 1'b0, hsum[4], sum9[8]};
			end
			cpualu_pkg::OP_SUB, cpualu_pkg::OP_SBC: begin
				r  = dif9[7:0];
				nf = {r == 8'd0, 1'b1, hdif[4], dif9[8]};
			end
			cpualu_pkg::OP_AND: begin
				r  = a & b;
				nf = {r == 8'd0, 1'b0, 1'b1, 1'b0};
			end
			cpualu_pkg::OP_INC: begin
				r  = a + 8'd1;
				nf = {r == 8'd0, 1'b0, a[3:0] == 4'hF, cin};
			end
			cpualu_pkg::OP_DEC: begin
				r  = a - 8'd1;
				nf = {r == 8'd0, 1'b1, a[3:0] == 4'h0, cin};
			end
			cpualu_pkg::OP_RLCA: begin
				r  = {a[6:0], a[7]};
				nf = {3'b000, a[7]};
			end
			cpualu_pkg::OP_RRCA: begin
				r  = {a[0], a[7:1]};
				nf = {3'b000, a[0]};
			end
			cpualu_pkg::OP_RLA: begin
				r  = {a[6:0], cin};
				nf = {3'b000, a[7]};
			end
			cpualu_pkg::OP_RRA: begin
				r  = {cin, a[7:1]};
				nf = {3'b000, a[0]};
			end
			cpualu_pkg::OP_DAA: begin
				r  = f[cpualu_pkg::FN] ? (a - adj) : (a + adj);
				nf = {r == 8'd0, f[cpualu_pkg::FN], 1'b0, daa_c};
			end
			cpualu_pkg::OP_CPL: begin
				r  = ~a;
				nf = {f[cpualu_pkg::FZ], 1'b1, 1'b1, cin};
			end
			cpualu_pkg::OP_SCF: nf = {f[cpualu_pkg::FZ], 3'b001};
			cpualu_pkg::OP_CCF: nf = {f[cpualu_pkg::FZ], 2'b00, ~cin};
			cpualu_pkg::OP_ADD16: begin
				w  = sum17[15:0];
				nf = {f[cpualu_pkg::FZ], 1'b0, sum13[12], sum17[16]};
			end
			cpualu_pkg::OP_INC16: w = item.wide_a + 16'd1;
			cpualu_pkg::OP_DEC16: w = item.wide_a - 16'd1;
			default: begin
				r  = a;
				w  = item.wide_a;
				nf = f;
			end
		endcase
	end

	assign res.byte_result = r;
	assign res.wide_result = w;
	assign res.flags_out   = nf;

endmodule

[tb/cpualu_checker.sv]
// Checker for the CPU ALU: watches both channels, predicts each result item
// and compares it field by field. Depends on cpualu_pkg and the channel interfaces.
`timescale 1ns / 1ps
module cpualu_checker (
	input  logic  clk,
	input  logic  arst_n,
	cpualu_in_if  item_in,
	cpualu_out_if item_out,
	output int    err_count,
	output int    outstanding
);
	import cpualu_pkg::*;

	out_item_t alu_results_q[$];
	int        errs;

	function automatic out_item_t alu_predict(input in_item_t it);
		logic [7:0]  a, b, r, adj;
		logic [15:0] w;
		logic [3:0]  f, nf;
		logic        cin, c;
		logic [8:0]  sum9;
		logic [4:0]  nib;
		logic [16:0] sum17;
		logic [12:0] low13;
		out_item_t   res;
		a   = it.operand_a;
		b   = it.operand_b;
		f   = it.flags_in;
		cin = f[FC];
		r   = a;
		w   = it.wide_a;
		nf  = f;
		case (it.op)
			OP_ADD, OP_ADC: begin
				c       = (it.op == OP_ADC) ? cin : 1'b0;
				sum9    = 9'(a) + 9'(b) + 9'(c);
				nib     = 5'(a[3:0]) + 5'(b[3:0]) + 5'(c);
				r       = sum9[7:0];
				nf      = '0;
				nf[FZ]  = (r == 8'h00);
				nf[FH]  = nib[4];
				nf[FC]  = sum9[8];
			end
			OP_SUB, OP_SBC: begin
				c       = (it.op == OP_SBC) ? cin : 1'b0;
				r       = a - b - 8'(c);
				nf      = '0;
				nf[FZ]  = (r == 8'h00);
				nf[FN]  = 1'b1;
				nf[FH]  = 5'(a[3:0]) < 5'(b[3:0]) + 5'(c);
				nf[FC]  = 9'(a) < 9'(b) + 9'(c);
			end
			OP_AND: begin
				r       = a & b;
				nf      = '0;
				nf[FZ]  = (r == 8'h00);
				nf[FH]  = 1'b1;
			end
			OP_INC: begin
				r       = a + 8'd1;
				nf      = '0;
				nf[FZ]  = (r == 8'h00);
				nf[FH]  = (a[3:0] == 4'hF);
				nf[FC]  = cin;
			end
			OP_DEC: begin
				r       = a - 8'd1;
				nf      = '0;
				nf[FZ]  = (r == 8'h00);
				nf[FN]  = 1'b1;
				nf[FH]  = (a[3:0] == 4'h0);
				nf[FC]  = cin;
			end
			OP_RLCA: begin
				r       = {a[6:0], a[7]};
				nf      = '0;
				nf[FC]  = a[7];
			end
			OP_RRCA: begin
				r       = {a[0], a[7:1]};
				nf      = '0;
				nf[FC]  = a[0];
			end
			OP_RLA: begin
				r       = {a[6:0], cin};
				nf      = '0;
				nf[FC]  = a[7];
			end
			OP_RRA: begin
				r       = {cin, a[7:1]};
				nf      = '0;
				nf[FC]  = a[0];
			end
			OP_DAA: begin
				adj = '0;
				c   = cin;
				if (!f[FN]) begin
					if (cin || a > DAA_LIMIT) begin
						adj = adj | DAA_HI_ADJ;
						c   = 1'b1;
					end
					if (f[FH] || a[3:0] > 4'd9)
						adj = adj | DAA_LO_ADJ;
					r = a + adj;
				end else begin
					// after a subtract the carry only selects the high correction
					if (cin)
						adj = adj | DAA_HI_ADJ;
					if (f[FH])
						adj = adj | DAA_LO_ADJ;
					r = a - adj;
				end
				nf      = '0;
				nf[FZ]  = (r == 8'h00);
				nf[FN]  = f[FN];
				nf[FC]  = c;
			end
			OP_CPL: begin
				r       = ~a;
				nf[FN]  = 1'b1;
				nf[FH]  = 1'b1;
			end
			OP_SCF: begin
				nf      = '0;
				nf[FZ]  = f[FZ];
				nf[FC]  = 1'b1;
			end
			OP_CCF: begin
				nf      = '0;
				nf[FZ]  = f[FZ];
				nf[FC]  = ~cin;
			end
			OP_ADD16: begin
				sum17   = 17'(it.wide_a) + 17'(it.wide_b);
				low13   = 13'(it.wide_a[11:0]) + 13'(it.wide_b[11:0]);
				w       = sum17[15:0];
				nf      = '0;
				nf[FZ]  = f[FZ];
				nf[FH]  = low13[12];
				nf[FC]  = sum17[16];
			end
			OP_INC16: w = it.wide_a + 16'd1;
			OP_DEC16: w = it.wide_a - 16'd1;
			default: ;
		endcase
		res.byte_result = r;
		res.wide_result = w;
		res.flags_out   = nf;
		return res;
	endfunction

	initial begin
		errs        = 0;
		err_count   = 0;
		outstanding = 0;
	end

	always @(posedge clk) begin
		in_item_t  seen;
		out_item_t got, want;
		if (arst_n) begin
			if (item_in.valid && item_in.ready) begin
				seen.op        = item_in.op;
				seen.operand_a = item_in.operand_a;
				seen.operand_b = item_in.operand_b;
				seen.wide_a    = item_in.wide_a;
				seen.wide_b    = item_in.wide_b;
				seen.flags_in  = item_in.flags_in;
				alu_results_q.push_back(alu_predict(seen));
			end
			if (item_out.valid && item_out.ready) begin
				got.byte_result = item_out.byte_result;
				got.wide_result = item_out.wide_result;
				got.flags_out   = item_out.flags_out;
				if (alu_results_q.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%0t: result item with nothing pending: byte %h wide %h flags %b",
							$realtime, got.byte_result, got.wide_result, got.flags_out);
				end else begin
					want = alu_results_q.pop_front();
					if (got.byte_result !== want.byte_result ||
					    got.wide_result !== want.wide_result ||
					    got.flags_out !== want.flags_out) begin
						errs++;
						if (errs <= 10)
							$display("%0t: mismatch: byte %h/%h wide %h/%h flags %b/%b (exp/got)",
								$realtime, want.byte_result, got.byte_result,
								want.wide_result, got.wide_result,
								want.flags_out, got.flags_out);
					end
				end
			end
			err_count   <= errs;
			outstanding <= alu_results_q.size();
		end
	end
endmodule

[tb/tb_top.sv]
// Testbench top for cpu_alu_with_flags_top: clock, reset, stimulus, receiver
// stalls and verdict. Depends on cpualu_pkg, the channel interfaces and cpualu_checker.
`timescale 1ns / 1ps
module tb_top;
	import cpualu_pkg::*;

	logic clk;
	logic arst_n;
	bit   tx_jitter;
	bit   rx_jitter;
	bit   hold_req;
	int   err_count;
	int   outstanding;

	cpualu_in_if  alu_in ();
	cpualu_out_if alu_out ();

	cpu_alu_with_flags_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_in  (alu_in),
		.item_out (alu_out)
	);

	cpualu_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_in     (alu_in),
		.item_out    (alu_out),
		.err_count   (err_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2_400_000;
		$display("tb_top: errors");
		$finish;
	end

	function automatic in_item_t mk_op(input logic [OP_W-1:0] op, input logic [7:0] a,
		input logic [7:0] b, input logic [15:0] wa, input logic [15:0] wb,
		input logic [3:0] f);
		in_item_t it;
		it.op        = op;
		it.operand_a = a;
		it.operand_b = b;
		it.wide_a    = wa;
		it.wide_b    = wb;
		it.flags_in  = f;
		return it;
	endfunction

	function automatic logic [7:0] rand_byte();
		logic [7:0] v;
		v = 8'($urandom);
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 5))
				0: v = 8'h00;
				1: v = 8'hFF;
				2: v = 8'h0F;
				3: v = 8'hF0;
				4: v = 8'h99;
				default: v = 8'h9A;
			endcase
		end
		return v;
	endfunction

	function automatic logic [15:0] rand_wide();
		logic [15:0] v;
		v = 16'($urandom);
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 5))
				0: v = 16'h0000;
				1: v = 16'hFFFF;
				2: v = 16'h0FFF;
				3: v = 16'h1000;
				4: v = 16'h8000;
				default: v = 16'h7FFF;
			endcase
		end
		return v;
	endfunction

	function automatic in_item_t rand_op();
		logic [OP_W-1:0] op;
		// a few unused codes as noise, the rest real operations
		if ($urandom_range(0, 99) < 6)
			op = OP_W'($urandom_range(18, 31));
		else
			op = OP_W'($urandom_range(0, 17));
		return mk_op(op, rand_byte(), rand_byte(), rand_wide(), rand_wide(),
			4'($urandom_range(0, 15)));
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_op(input in_item_t it);
		while (tx_jitter && $urandom_range(0, 99) < 25) begin
			alu_in.valid <= 1'b0;
			@(negedge clk);
		end
		alu_in.valid     <= 1'b1;
		alu_in.op        <= it.op;
		alu_in.operand_a <= it.operand_a;
		alu_in.operand_b <= it.operand_b;
		alu_in.wide_a    <= it.wide_a;
		alu_in.wide_b    <= it.wide_b;
		alu_in.flags_in  <= it.flags_in;
		do @(posedge clk); while (!alu_in.ready);
		@(negedge clk);
	endtask

	task automatic send_random(input int count);
		repeat (count) send_op(rand_op());
	endtask

	// receiver: random stalls, plus a long hold when requested
	initial begin
		int stall_left;
		stall_left    = 0;
		alu_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				stall_left = 64;
				hold_req   = 1'b0;
			end
			if (stall_left > 0) begin
				alu_out.ready <= 1'b0;
				stall_left--;
			end else begin
				alu_out.ready <= !(rx_jitter && $urandom_range(0, 99) < 25);
			end
		end
	end

	initial begin
		arst_n           = 1'b0;
		tx_jitter        = 1'b1;
		rx_jitter        = 1'b1;
		hold_req         = 1'b0;
		alu_in.valid     = 1'b0;
		alu_in.op        = '0;
		alu_in.operand_a = '0;
		alu_in.operand_b = '0;
		alu_in.wide_a    = '0;
		alu_in.wide_b    = '0;
		alu_in.flags_in  = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed: field extremes, every operation, flag corner cases
		send_op(mk_op(OP_ADD,   8'hFF, 8'h01, 16'h0000, 16'h0000, 4'b0000));
		send_op(mk_op(OP_ADD,   8'h00, 8'h00, 16'hFFFF, 16'hFFFF, 4'b1111));
		send_op(mk_op(OP_ADC,   8'h0F, 8'h00, 16'h1234, 16'h0000, 4'b0001));
		send_op(mk_op(OP_ADC,   8'hFF, 8'hFF, 16'h0000, 16'h0000, 4'b0001));
		send_op(mk_op(OP_SUB,   8'h00, 8'h01, 16'h0000, 16'h0000, 4'b0000));
		send_op(mk_op(OP_SUB,   8'h3C, 8'h3C, 16'h0000, 16'h0000, 4'b0001));
		send_op(mk_op(OP_SBC,   8'h10, 8'h0F, 16'h0000, 16'h0000, 4'b0001));
		send_op(mk_op(OP_SBC,   8'h00, 8'hFF, 16'h0000, 16'h0000, 4'b0001));
		send_op(mk_op(OP_AND,   8'hF0, 8'h0F, 16'h0000, 16'h0000, 4'b0101));
		send_op(mk_op(OP_INC,   8'hFF, 8'h00, 16'h0000, 16'h0000, 4'b0001));
		send_op(mk_op(OP_INC,   8'h0F, 8'h00, 16'h0000, 16'h0000, 4'b0000));
		send_op(mk_op(OP_DEC,   8'h00, 8'h00, 16'h0000, 16'h0000, 4'b0001));
		send_op(mk_op(OP_DEC,   8'h01, 8'h00, 16'h0000, 16'h0000, 4'b0000));
		send_op(mk_op(OP_RLCA,  8'h80, 8'h00, 16'h0000, 16'h0000, 4'b1110));
		send_op(mk_op(OP_RRCA,  8'h01, 8'h00, 16'h0000, 16'h0000, 4'b1110));
		send_op(mk_op(OP_RLA,   8'h00, 8'h00, 16'h0000, 16'h0000, 4'b1001));
		send_op(mk_op(OP_RRA,   8'h01, 8'h00, 16'h0000, 16'h0000, 4'b0000));
		send_op(mk_op(OP_DAA,   8'h9A, 8'h00, 16'h0000, 16'h0000, 4'b0000));
		send_op(mk_op(OP_DAA,   8'h00, 8'h00, 16'h0000, 16'h0000, 4'b0010));
		send_op(mk_op(OP_DAA,   8'h00, 8'h00, 16'h0000, 16'h0000, 4'b0111));
		send_op(mk_op(OP_CPL,   8'h5A, 8'h00, 16'h0000, 16'h0000, 4'b1000));
		send_op(mk_op(OP_SCF,   8'h00, 8'h00, 16'h0000, 16'h0000, 4'b1110));
		send_op(mk_op(OP_CCF,   8'h00, 8'h00, 16'h0000, 16'h0000, 4'b1001));
		send_op(mk_op(OP_ADD16, 8'h00, 8'h00, 16'hFFFF, 16'h0001, 4'b1000));
		send_op(mk_op(OP_ADD16, 8'h00, 8'h00, 16'h0FFF, 16'h0001, 4'b0000));
		send_op(mk_op(OP_INC16, 8'h00, 8'h00, 16'hFFFF, 16'h0000, 4'b1111));
		send_op(mk_op(OP_DEC16, 8'h00, 8'h00, 16'h0000, 16'h0000, 4'b0000));
		send_op(mk_op(OP_W'(31), 8'hA5, 8'h5A, 16'hBEEF, 16'h1234, 4'b1010));

		send_random(150);

		// long receiver hold while the sender keeps offering: block fills, input stalls
		alu_in.valid <= 1'b0;
		@(posedge clk) hold_req = 1'b1;
		@(negedge clk);
		tx_jitter = 1'b0;
		send_random(24);

		// sender pauses until the pipe has drained
		alu_in.valid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);

		// stretch with no idling on either side
		rx_jitter = 1'b0;
		send_random(130);
		tx_jitter = 1'b1;
		rx_jitter = 1'b1;
		send_random(130);

		alu_in.valid <= 1'b0;
		wait (outstanding == 0);
		repeat (8) @(posedge clk);
		if (err_count == 0 && outstanding == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule
